// ===== src/gtcw_pkg.sv =====
// gtcw_pkg: shared types, codes and the 5x7 font for the GLCD text writer.
// No dependencies; imported by every module of the block.
package gtcw_pkg;

  // Input item and result item payloads
  typedef struct packed {
    logic       func;
    logic [2:0] row_select;
    logic [4:0] column_select;
    logic [7:0] char_code;
  } gtcw_item_t;

  typedef struct packed {
    logic [1:0] chip_select;
    logic       data_not_command;
    logic [7:0] bus_byte;
    logic       last;
  } gtcw_result_t;

  // Cursor configuration registers
  typedef struct packed {
    logic       enable;
    logic [2:0] row;
    logic [4:0] column;
  } gtcw_cursor_t;

  // Position update command from the sequencer to the position register
  typedef struct packed {
    logic       set;
    logic       advance;
    logic [2:0] row;
    logic [4:0] column;
  } gtcw_pos_cmd_t;

  // Item functions
  localparam logic FUNC_SET_POS = 1'b0;
  localparam logic FUNC_CHAR    = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_CURSOR_ENABLE = 2'd0;
  localparam logic [1:0] REG_CURSOR_ROW    = 2'd1;
  localparam logic [1:0] REG_CURSOR_COLUMN = 2'd2;

  // Chip selects
  localparam logic [1:0] CHIP_LEFT  = 2'd1;
  localparam logic [1:0] CHIP_RIGHT = 2'd2;
  localparam logic [1:0] CHIP_BOTH  = 2'd3;

  // Bus write codes
  localparam logic       BUS_CMD  = 1'b0;
  localparam logic       BUS_DATA = 1'b1;
  localparam logic [7:0] CMD_PAGE   = 8'hB8;
  localparam logic [7:0] CMD_COLUMN = 8'h40;
  localparam logic [7:0] LEFT_OFFSET = 8'd4;
  localparam logic [4:0] LEFT_CELLS  = 5'd10;
  localparam logic [7:0] UNDERLINE   = 8'h80;

  // Beats of one character
  localparam logic [2:0] BEAT_PAGE   = 3'd0;
  localparam logic [2:0] BEAT_COLUMN = 3'd1;
  localparam logic [2:0] BEAT_BLANK  = 3'd7;

  // Printable range
  localparam logic [7:0] CHAR_FIRST = 8'h20;
  localparam logic [7:0] CHAR_LAST  = 8'h7E;

  // Font: five column bytes per glyph, first column in the top byte.
  function automatic logic [39:0] glyph_row(input logic [6:0] idx);
    logic [39:0] g;
    unique case (idx)
      7'd0:  g = 40'h0000000000;
      7'd1:  g = 40'h00004f0000;
      7'd2:  g = 40'h0007000700;
      7'd3:  g = 40'h147f147f14;
      7'd4:  g = 40'h242a7f2a12;
      7'd5:  g = 40'h2313086462;
      7'd6:  g = 40'h3649552250;
      7'd7:  g = 40'h0005030000;
      7'd8:  g = 40'h001c224100;
      7'd9:  g = 40'h0041221c00;
      7'd10: g = 40'h14083e0814;
      7'd11: g = 40'h08083e0808;
      7'd12: g = 40'h0050300000;
      7'd13: g = 40'h0808080808;
      7'd14: g = 40'h0060600000;
      7'd15: g = 40'h2010080402;
      7'd16: g = 40'h3e5149453e;
      7'd17: g = 40'h00427f4000;
      7'd18: g = 40'h4261514946;
      7'd19: g = 40'h2141454b31;
      7'd20: g = 40'h1814127f10;
      7'd21: g = 40'h2745454539;
      7'd22: g = 40'h3c4a494930;
      7'd23: g = 40'h0171090503;
      7'd24: g = 40'h3649494936;
      7'd25: g = 40'h064949291e;
      7'd26: g = 40'h0036360000;
      7'd27: g = 40'h0056360000;
      7'd28: g = 40'h0814224100;
      7'd29: g = 40'h1414141414;
      7'd30: g = 40'h0041221408;
      7'd31: g = 40'h0201510906;
      7'd32: g = 40'h324979413e;
      7'd33: g = 40'h7e1111117e;
      7'd34: g = 40'h7f49494936;
      7'd35: g = 40'h3e41414122;
      7'd36: g = 40'h7f4141221c;
      7'd37: g = 40'h7f49494941;
      7'd38: g = 40'h7f09090901;
      7'd39: g = 40'h3e4149497a;
      7'd40: g = 40'h7f0808087f;
      7'd41: g = 40'h00417f4100;
      7'd42: g = 40'h2040413f01;
      7'd43: g = 40'h7f08142241;
      7'd44: g = 40'h7f40404040;
      7'd45: g = 40'h7f020c027f;
      7'd46: g = 40'h7f0408107f;
      7'd47: g = 40'h3e4141413e;
      7'd48: g = 40'h7f09090906;
      7'd49: g = 40'h3e4151215e;
      7'd50: g = 40'h7f09192946;
      7'd51: g = 40'h2649494932;
      7'd52: g = 40'h01017f0101;
      7'd53: g = 40'h3f4040403f;
      7'd54: g = 40'h1f2040201f;
      7'd55: g = 40'h3f4038403f;
      7'd56: g = 40'h6314081463;
      7'd57: g = 40'h0708700807;
      7'd58: g = 40'h6151494543;
      7'd59: g = 40'h007f414100;
      7'd60: g = 40'h0204081020;
      7'd61: g = 40'h0041417f00;
      7'd62: g = 40'h0402010204;
      7'd63: g = 40'h4040404040;
      7'd64: g = 40'h0001020400;
      7'd65: g = 40'h2054545478;
      7'd66: g = 40'h7f48444438;
      7'd67: g = 40'h3844444420;
      7'd68: g = 40'h384444487f;
      7'd69: g = 40'h3854545418;
      7'd70: g = 40'h087e090102;
      7'd71: g = 40'h0c5252523e;
      7'd72: g = 40'h7f08040478;
      7'd73: g = 40'h00047d0000;
      7'd74: g = 40'h2040443d00;
      7'd75: g = 40'h7f10284400;
      7'd76: g = 40'h00417f4000;
      7'd77: g = 40'h7c0418047c;
      7'd78: g = 40'h7c08040478;
      7'd79: g = 40'h3844444438;
      7'd80: g = 40'h7c14141408;
      7'd81: g = 40'h081414187c;
      7'd82: g = 40'h7c08040408;
      7'd83: g = 40'h4854545420;
      7'd84: g = 40'h043f444020;
      7'd85: g = 40'h3c4040207c;
      7'd86: g = 40'h1c2040201c;
      7'd87: g = 40'h3c4030403c;
      7'd88: g = 40'h4428102844;
      7'd89: g = 40'h0c5050503c;
      7'd90: g = 40'h4464544c44;
      7'd91: g = 40'h0008364100;
      7'd92: g = 40'h0000770000;
      7'd93: g = 40'h0041360800;
      7'd94: g = 40'h0804081008;
      default: g = 40'h0000000000;
    endcase
    return g;
  endfunction

endpackage

// ===== src/gtcw_position.sv =====
// gtcw_position: text row/column register with set and advance.
// Depends on gtcw_pkg.
module gtcw_position import gtcw_pkg::*; #(
  parameter int COLUMNS_PER_ROW = 20,
  parameter int TEXT_ROWS       = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  gtcw_pos_cmd_t cmd,
  output logic [2:0]    text_row,
  output logic [4:0]    text_column
);

  localparam logic [4:0] LAST_COLUMN = 5'(COLUMNS_PER_ROW - 1);
  localparam logic [2:0] LAST_ROW    = 3'(TEXT_ROWS - 1);
  localparam logic [3:0] ROWS        = 4'(TEXT_ROWS);

  logic [2:0] text_row_next;
  logic [4:0] text_column_next;
  logic [3:0] row_mod;

  // Fold the requested row into range by repeated subtraction.
  always_comb begin
    row_mod = {1'b0, cmd.row};
    for (int k = 0; k < 8; k++) begin
      if (row_mod >= ROWS) begin
        row_mod = row_mod - ROWS;
      end
    end
  end

  always_comb begin
    text_row_next    = text_row;
    text_column_next = text_column;
    priority if (cmd.set) begin
      text_row_next    = row_mod[2:0];
      text_column_next = (cmd.column > LAST_COLUMN) ? LAST_COLUMN : cmd.column;
    end else if (cmd.advance) begin
      if (text_column >= LAST_COLUMN) begin
        text_column_next = '0;
        text_row_next    = (text_row >= LAST_ROW) ? 3'd0 : text_row + 3'd1;
      end else begin
        text_column_next = text_column + 5'd1;
      end
    end else begin
      // Hold the position.
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_row    <= '0;
      text_column <= '0;
    end else begin
      text_row    <= text_row_next;
      text_column <= text_column_next;
    end
  end

endmodule

// ===== src/gtcw_beat.sv =====
// gtcw_beat: forms one bus write of a character from the beat number.
// Depends on gtcw_pkg (font and bus codes).
module gtcw_beat import gtcw_pkg::*; (
  input  logic [2:0]   beat,
  input  logic [7:0]   char_code,
  input  logic [2:0]   text_row,
  input  logic [4:0]   text_column,
  input  gtcw_cursor_t cursor,
  output gtcw_result_t result
);

  logic        left;
  logic [4:0]  cell_pos;
  logic [7:0]  cell_x6;
  logic [7:0]  col_cmd;
  logic [1:0]  chip;
  logic [6:0]  glyph_idx;
  logic [39:0] glyph;
  logic [7:0]  glyph_byte;
  logic [7:0]  mark;
  logic [2:0]  glyph_col;

  always_comb begin
    left     = (text_column < LEFT_CELLS);
    cell_pos = left ? text_column : text_column - LEFT_CELLS;
    cell_x6  = {2'b0, cell_pos, 1'b0} + {1'b0, cell_pos, 2'b0};
    col_cmd  = CMD_COLUMN + cell_x6 + (left ? LEFT_OFFSET : 8'd0);
    chip     = left ? CHIP_LEFT : CHIP_RIGHT;

    // Unprintable codes draw as a space.
    glyph_idx = (char_code >= CHAR_FIRST && char_code <= CHAR_LAST)
              ? 7'(char_code - CHAR_FIRST) : 7'd0;
    glyph     = glyph_row(glyph_idx);
    glyph_col = beat - 3'd2;
    unique case (glyph_col)
      3'd0:    glyph_byte = glyph[39:32];
      3'd1:    glyph_byte = glyph[31:24];
      3'd2:    glyph_byte = glyph[23:16];
      3'd3:    glyph_byte = glyph[15:8];
      3'd4:    glyph_byte = glyph[7:0];
      default: glyph_byte = 8'h00;
    endcase
    mark = (cursor.enable && cursor.row == text_row && cursor.column == text_column)
         ? UNDERLINE : 8'h00;

    result.last = 1'b0;
    unique case (beat)
      BEAT_PAGE: begin
        result.chip_select      = CHIP_BOTH;
        result.data_not_command = BUS_CMD;
        result.bus_byte         = CMD_PAGE + {5'b0, text_row};
      end
      BEAT_COLUMN: begin
        result.chip_select      = chip;
        result.data_not_command = BUS_CMD;
        result.bus_byte         = col_cmd;
      end
      BEAT_BLANK: begin
        result.chip_select      = chip;
        result.data_not_command = BUS_DATA;
        result.bus_byte         = 8'h00;
        result.last             = 1'b1;
      end
      default: begin
        result.chip_select      = chip;
        result.data_not_command = BUS_DATA;
        result.bus_byte         = glyph_byte | mark;
      end
    endcase
  end

endmodule

// ===== src/glcd_text_character_writer_top.sv =====
// glcd_text_character_writer_top: 5x7 text renderer for a two-controller GLCD.
// Depends on gtcw_pkg, gtcw_position and gtcw_beat.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------
//   in       | input     | in_valid / in_ready   | in_data  (gtcw_item_t)
//   out      | output    | out_valid / out_ready | out_data (gtcw_result_t)
//   cfg      | input     | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// A character item yields eight bus writes, one per cycle while the output
// register is not stalled; a set-position item produces no output.
// The next item is taken in the cycle the current one finishes, so items
// stream back to back. The output register stalls the sequencer while it
// holds a write and out_ready is low. Reset (rst, synchronous) clears the text
// position, the cursor registers and all valid flags.
module glcd_text_character_writer_top import gtcw_pkg::*; #(
  parameter int COLUMNS_PER_ROW = 20,
  parameter int TEXT_ROWS       = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  gtcw_item_t   in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output gtcw_result_t out_data,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [4:0]   cfg_wdata
);

  // Input register: the item under work
  logic       item_valid;
  gtcw_item_t item;
  logic [2:0] beat;

  gtcw_cursor_t  cursor;
  gtcw_pos_cmd_t pos_cmd;
  gtcw_result_t  beat_result;
  logic [2:0]    text_row;
  logic [4:0]    text_column;

  logic out_free;
  logic is_char;
  logic emit;
  logic item_done;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CURSOR_ENABLE: cursor.enable <= cfg_wdata[0];
        REG_CURSOR_ROW:    cursor.row    <= cfg_wdata[2:0];
        REG_CURSOR_COLUMN: cursor.column <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Emit a beat whenever the output register can take it.
  assign out_free  = !out_valid || out_ready;
  assign is_char   = (item.func == FUNC_CHAR);
  assign emit      = item_valid && is_char && out_free;
  assign item_done = item_valid && (!is_char || (emit && beat == BEAT_BLANK));
  assign in_ready  = !item_valid || item_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      beat       <= BEAT_PAGE;
    end else begin
      if (in_valid && in_ready) begin
        item_valid <= 1'b1;
      end else if (item_done) begin
        item_valid <= 1'b0;
      end
      // Advance the beat; it wraps to the page beat after the blank byte.
      if (emit) begin
        beat <= beat + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  // Set position on a set item; advance after the last beat of a character.
  always_comb begin
    pos_cmd.set     = item_done && !is_char;
    pos_cmd.advance = emit && (beat == BEAT_BLANK);
    pos_cmd.row     = item.row_select;
    pos_cmd.column  = item.column_select;
  end

  gtcw_position #(
    .COLUMNS_PER_ROW (COLUMNS_PER_ROW),
    .TEXT_ROWS       (TEXT_ROWS)
  ) u_position (
    .clk         (clk),
    .rst         (rst),
    .cmd         (pos_cmd),
    .text_row    (text_row),
    .text_column (text_column)
  );

  gtcw_beat u_beat (
    .beat        (beat),
    .char_code   (item.char_code),
    .text_row    (text_row),
    .text_column (text_column),
    .cursor      (cursor),
    .result      (beat_result)
  );

  // Output register: hold the write until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= beat_result;
    end
  end

endmodule
